@@ rtl/shared_exclusive_lock_table_unit_assert.svh @@
// assertion macros shared by the lock table modules
`ifndef SHARED_EXCLUSIVE_LOCK_TABLE_UNIT_ASSERT_SVH
`define SHARED_EXCLUSIVE_LOCK_TABLE_UNIT_ASSERT_SVH

// clocked assertion, off while reset is asserted
`define SELT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// clocked assertion that is also checked during reset
`define SELT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

@@ rtl/selt_pkg.sv @@
`timescale 1ns / 1ps
package selt_pkg;

    localparam logic [1:0] ACT_ACQUIRE = 2'd0;
    localparam logic [1:0] ACT_RELEASE = 2'd1;
    localparam logic [1:0] ACT_QUERY   = 2'd2;
    localparam logic [1:0] ACT_NONE    = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BLOCKED = 2'd1;
    localparam logic [1:0] ST_TFULL   = 2'd2;
    localparam logic [1:0] ST_HFULL   = 2'd3;

    localparam int IN_BYTES  = 7;
    localparam int OUT_BYTES = 3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND,
        S_SCAN,
        S_SCHK,
        S_ADEC,
        S_ANEW,
        S_RESP,
        S_QRD,
        S_QOUT,
        S_RENT,
        S_RSCAN,
        S_RCHK,
        S_RFIN
    } t_state;

    typedef struct packed {
        logic latch;
        logic find;
        logic use_i;
        logic i_clr;
        logic i_inc;
        logic j_clr;
        logic j_inc;
        logic rd;
        logic chk;
        logic shift;
        logic acq_dec;
        logic acq_new;
        logic rel_fin;
        logic out_load;
        logic out_hold;
    } t_cmd;

    typedef struct packed {
        logic [1:0] act;
        logic       hit;
        logic       j_lt;
        logic       i_done;
        logic       used_i;
        logic       out_free;
        logic       q_last;
    } t_sts;

endpackage

@@ rtl/shared_exclusive_lock_table_unit.sv @@
`timescale 1ns / 1ps
// channel   dir  tdata (low bit up)                        tuser    tlast
// s_*       in   txn_id[15:0] record_key[47:16] mode[48]   action   -
// m_*       out  status[1:0] holder_valid[2] holder_txn    -        last
//
// acquire: looks up the key, then scans the holders of a present key or allocates a new entry
// release: walks every table entry, scanning and shifting the holders of each used entry
// query: streams each holder of a present key from the holder ram
// reset is synchronous; no input is taken while a word is in work
// a stalled output holds the controller until the waiting word is taken
module shared_exclusive_lock_table_unit import selt_pkg::*; #(
    parameter int TABLE_ENTRIES = 16,
    parameter int MAX_HOLDERS   = 8,
    parameter int KEY_BITS      = 32,
    parameter int TXN_BITS      = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [8*IN_BYTES-1:0]  s_tdata,  // txn_id, record_key, lock_mode
    input  logic [1:0]             s_tuser,  // action
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [8*OUT_BYTES-1:0] m_tdata,  // status, holder_valid, holder_txn
    output logic                   m_tlast
);

    t_cmd cmd;
    t_sts sts;

    selt_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(s_tvalid),
        .o_in_ready(s_tready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    selt_datapath #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .MAX_HOLDERS  (MAX_HOLDERS),
        .KEY_BITS     (KEY_BITS),
        .TXN_BITS     (TXN_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_act      (s_tuser),
        .i_txn      (s_tdata[15:0]),
        .i_key      (s_tdata[47:16]),
        .i_mode     (s_tdata[48]),
        .i_out_ready(m_tready),
        .o_out_valid(m_tvalid),
        .o_out_data (m_tdata),
        .o_out_last (m_tlast)
    );

endmodule

@@ rtl/selt_ram.sv @@
`timescale 1ns / 1ps
module selt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/selt_datapath.sv @@
`timescale 1ns / 1ps
module selt_datapath import selt_pkg::*; #(
    parameter int TABLE_ENTRIES = 16,
    parameter int MAX_HOLDERS   = 8,
    parameter int KEY_BITS      = 32,
    parameter int TXN_BITS      = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic [1:0]            i_act,
    input  logic [15:0]           i_txn,
    input  logic [31:0]           i_key,
    input  logic                  i_mode,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [8*OUT_BYTES-1:0] o_out_data,
    output logic                  o_out_last
);

    `include "shared_exclusive_lock_table_unit_assert.svh"

    localparam int TW = (TXN_BITS < 16) ? TXN_BITS : 16;
    localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;
    localparam int EB = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(MAX_HOLDERS + 1);
    localparam int HB = (MAX_HOLDERS > 1) ? $clog2(MAX_HOLDERS) : 1;
    localparam int AW = EB + HB;
    localparam int DEPTH = TABLE_ENTRIES << HB;

    logic [1:0]    r_act;
    logic [TW-1:0] r_txn;
    logic [KW-1:0] r_key;
    logic          r_mode;

    logic          r_used [TABLE_ENTRIES];
    logic [KW-1:0] r_ekey [TABLE_ENTRIES];
    logic          r_excl [TABLE_ENTRIES];
    logic [CW-1:0] r_cnt  [TABLE_ENTRIES];

    logic [EB-1:0] r_e;
    logic [EB-1:0] r_free;
    logic          r_free_ok;
    logic [EB:0]   r_i;
    logic [CW-1:0] r_j;
    logic          r_found;
    logic [1:0]    r_status;

    logic                  r_out_valid;
    logic [8*OUT_BYTES-1:0] r_out_data;
    logic                  r_out_last;

    logic          hit;
    logic [EB-1:0] hit_idx;
    logic          free_ok;
    logic [EB-1:0] free_idx;
    logic [EB-1:0] sel_e;
    logic [CW-1:0] cnt_sel;
    logic [CW-1:0] jm1;
    logic [TW-1:0] rd_q;
    logic          we;
    logic [AW-1:0] waddr;
    logic [TW-1:0] wdata;
    logic [1:0]    dec_status;
    logic          dec_append;
    logic          out_free;

    always_comb begin
        hit      = 1'b0;
        hit_idx  = '0;
        free_ok  = 1'b0;
        free_idx = '0;
        for (int k = TABLE_ENTRIES - 1; k >= 0; k--) begin
            if (r_used[k] && r_ekey[k] == r_key) begin
                hit     = 1'b1;
                hit_idx = EB'(k);
            end
            if (!r_used[k]) begin
                free_ok  = 1'b1;
                free_idx = EB'(k);
            end
        end
    end

    assign sel_e    = i_cmd.use_i ? r_i[EB-1:0] : r_e;
    assign cnt_sel  = r_cnt[sel_e];
    assign jm1      = r_j - 1'b1;
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        dec_append = 1'b0;
        if (r_found && (r_excl[r_e] || !r_mode)) begin
            dec_status = ST_OK;
        end else if (r_excl[r_e] || r_mode) begin
            dec_status = ST_BLOCKED;
        end else if (r_cnt[r_e] >= CW'(MAX_HOLDERS)) begin
            dec_status = ST_HFULL;
        end else begin
            dec_status = ST_OK;
            dec_append = 1'b1;
        end
    end

    always_comb begin
        we    = 1'b0;
        waddr = {r_e, r_cnt[r_e][HB-1:0]};
        wdata = r_txn;
        if (i_cmd.acq_dec && dec_append) begin
            we = 1'b1;
        end else if (i_cmd.acq_new && r_free_ok) begin
            we    = 1'b1;
            waddr = {r_free, {HB{1'b0}}};
        end else if (i_cmd.shift && r_found) begin
            we    = 1'b1;
            waddr = {r_i[EB-1:0], jm1[HB-1:0]};
            wdata = rd_q;
        end
    end

    selt_ram #(
        .WIDTH(TW),
        .DEPTH(DEPTH)
    ) u_holders (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_re   (i_cmd.rd),
        .i_raddr({sel_e, r_j[HB-1:0]}),
        .o_rdata(rd_q)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_act  <= i_act;
            r_txn  <= i_txn[TW-1:0];
            r_key  <= i_key[KW-1:0];
            r_mode <= i_mode;
        end
        if (i_cmd.find) begin
            r_e       <= hit_idx;
            r_free    <= free_idx;
            r_free_ok <= free_ok;
        end
        if (i_cmd.acq_new && r_free_ok) begin
            r_ekey[r_free] <= r_key;
            r_excl[r_free] <= r_mode;
        end
        if (i_cmd.i_clr) begin
            r_i <= '0;
        end else if (i_cmd.i_inc) begin
            r_i <= r_i + 1'b1;
        end
        if (i_cmd.find || i_cmd.j_clr) begin
            r_j <= '0;
        end else if (i_cmd.j_inc) begin
            r_j <= r_j + 1'b1;
        end
        if (i_cmd.out_load) begin
            r_out_last <= i_cmd.out_hold ? o_sts.q_last : 1'b1;
            r_out_data <= '0;
            if (i_cmd.out_hold) begin
                r_out_data[18:0] <= {16'(rd_q), 1'b1, ST_OK};
            end else begin
                r_out_data[1:0] <= r_status;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found     <= 1'b0;
            r_status    <= ST_OK;
            r_out_valid <= 1'b0;
            for (int k = 0; k < TABLE_ENTRIES; k++) begin
                r_used[k] <= 1'b0;
                r_cnt[k]  <= '0;
            end
        end else begin
            if (i_cmd.latch) begin
                r_status <= ST_OK;
            end
            if (i_cmd.find || i_cmd.j_clr) begin
                r_found <= 1'b0;
            end else if (i_cmd.chk && rd_q == r_txn) begin
                r_found <= 1'b1;
            end
            if (i_cmd.acq_dec) begin
                r_status <= dec_status;
                if (dec_append) begin
                    r_cnt[r_e] <= r_cnt[r_e] + 1'b1;
                end
            end
            if (i_cmd.acq_new) begin
                if (r_free_ok) begin
                    r_used[r_free] <= 1'b1;
                    r_cnt[r_free]  <= CW'(1);
                end else begin
                    r_status <= ST_TFULL;
                end
            end
            if (i_cmd.rel_fin && r_found) begin
                r_cnt[r_i[EB-1:0]] <= r_cnt[r_i[EB-1:0]] - 1'b1;
                if (r_cnt[r_i[EB-1:0]] == CW'(1)) begin
                    r_used[r_i[EB-1:0]] <= 1'b0;
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.act      = r_act;
    assign o_sts.hit      = hit;
    assign o_sts.j_lt     = r_j < cnt_sel;
    assign o_sts.i_done   = r_i == (EB + 1)'(TABLE_ENTRIES);
    assign o_sts.used_i   = r_used[r_i[EB-1:0]];
    assign o_sts.out_free = out_free;
    assign o_sts.q_last   = ({1'b0, r_j} + 1'b1) == {1'b0, cnt_sel};

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_last  = r_out_last;

    `SELT_ASSERT(a_load_free, i_cmd.out_load |-> out_free, "result loaded over a waiting word")
    `SELT_ASSERT(a_rd_in_list, i_cmd.rd |-> o_sts.j_lt, "holder read beyond list end")
    `SELT_ASSERT(a_out_held, r_out_valid && !i_out_ready |=> r_out_valid && $stable(r_out_data),
        "waiting result changed")

endmodule

@@ rtl/selt_ctrl.sv @@
`timescale 1ns / 1ps
module selt_ctrl import selt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    `include "shared_exclusive_lock_table_unit_assert.svh"

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_FIND;
            S_FIND: begin
                case (i_sts.act)
                    ACT_ACQUIRE: n_state = i_sts.hit ? S_SCAN : S_ANEW;
                    ACT_RELEASE: n_state = S_RENT;
                    ACT_QUERY:   n_state = i_sts.hit ? S_QRD : S_RESP;
                    default:     n_state = S_IDLE;
                endcase
            end
            S_SCAN:  n_state = i_sts.j_lt ? S_SCHK : S_ADEC;
            S_SCHK:  n_state = S_SCAN;
            S_ADEC:  n_state = S_RESP;
            S_ANEW:  n_state = S_RESP;
            S_RESP:  if (i_sts.out_free) n_state = S_IDLE;
            S_QRD:   n_state = S_QOUT;
            S_QOUT: begin
                if (i_sts.out_free) n_state = i_sts.q_last ? S_IDLE : S_QRD;
            end
            S_RENT: begin
                if (i_sts.i_done) begin
                    n_state = S_RESP;
                end else if (i_sts.used_i) begin
                    n_state = S_RSCAN;
                end
            end
            S_RSCAN: n_state = i_sts.j_lt ? S_RCHK : S_RFIN;
            S_RCHK:  n_state = S_RSCAN;
            S_RFIN:  n_state = S_RENT;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.latch = i_in_valid;
            end
            S_FIND: begin
                o_cmd.find  = 1'b1;
                o_cmd.i_clr = 1'b1;
            end
            S_SCAN:  o_cmd.rd = i_sts.j_lt;
            S_SCHK: begin
                o_cmd.chk   = 1'b1;
                o_cmd.j_inc = 1'b1;
            end
            S_ADEC:  o_cmd.acq_dec = 1'b1;
            S_ANEW:  o_cmd.acq_new = 1'b1;
            S_RESP:  o_cmd.out_load = i_sts.out_free;
            S_QRD:   o_cmd.rd = 1'b1;
            S_QOUT: begin
                o_cmd.out_load = i_sts.out_free;
                o_cmd.out_hold = 1'b1;
                o_cmd.j_inc    = i_sts.out_free;
            end
            S_RENT: begin
                o_cmd.use_i = 1'b1;
                o_cmd.j_clr = !i_sts.i_done && i_sts.used_i;
                o_cmd.i_inc = !i_sts.i_done && !i_sts.used_i;
            end
            S_RSCAN: begin
                o_cmd.use_i = 1'b1;
                o_cmd.rd    = i_sts.j_lt;
            end
            S_RCHK: begin
                o_cmd.use_i = 1'b1;
                o_cmd.chk   = 1'b1;
                o_cmd.shift = 1'b1;
                o_cmd.j_inc = 1'b1;
            end
            S_RFIN: begin
                o_cmd.use_i   = 1'b1;
                o_cmd.rel_fin = 1'b1;
                o_cmd.i_inc   = 1'b1;
            end
            default: ;
        endcase
    end

    `SELT_ASSERT(a_ready_idle, o_in_ready |-> r_state == S_IDLE, "input taken while busy")
    `SELT_ASSERT(a_accept_find, i_in_valid && o_in_ready |=> r_state == S_FIND,
        "accepted word not looked up")
    `SELT_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> r_state == S_IDLE, "reset left controller busy")

endmodule
